// File: sv/lsam_pkg.sv
// lsam_pkg: shared types, constants and helpers of the label slice area max block.
// No dependencies; imported by every module of the block except lsam_ram.
package lsam_pkg;

    localparam int MAX_LABELS = 1024;
    localparam int LABEL_W    = $clog2(MAX_LABELS);
    localparam int CNT_W      = LABEL_W + 1;
    localparam int COUNT_W    = 17;
    localparam int AREA_W     = 32;
    localparam int NF_W       = 11;
    localparam int RES_W      = COUNT_W + AREA_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic OP_VOXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_AREA    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 1'b1;

    localparam logic [AREA_W-1:0] CELL_AREA_RST    = 32'h0001_0000;
    localparam logic [NF_W-1:0]   NUM_FEATURES_RST = NF_W'(MAX_LABELS);

    typedef struct packed {
        logic               operation;
        logic [LABEL_W-1:0] feature_id;
        logic               last_in_slice;
    } t_in_word;

    typedef struct packed {
        logic [LABEL_W-1:0] feature_id_res;
        logic [RES_W-1:0]   largest_area;
        logic               in_range;
    } t_out_word;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_MAX,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [COUNT_W-1:0]  a;
        logic [AREA_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [LABEL_W-1:0] raddr;
        logic [LABEL_W-1:0] waddr;
        logic               s_we;
        logic [COUNT_W-1:0] s_wdata;
        logic               l_we;
        logic [COUNT_W-1:0] l_wdata;
    } t_mem_ctl;

    // label limit is min(num_features, MAX_LABELS); labels never reach MAX_LABELS
    function automatic logic in_limit(input logic [LABEL_W-1:0] id,
                                      input logic [NF_W-1:0]    nf);
        logic [NF_W-1:0] lim;
        lim = (nf > NF_W'(MAX_LABELS)) ? NF_W'(MAX_LABELS) : nf;
        return (NF_W'(id) < lim);
    endfunction

endpackage

// File: sv/label_slice_area_max.sv
// label_slice_area_max: top level; ties the sequencer, shared ALU and two count RAMs.
// Depends on lsam_pkg, lsam_seq, lsam_alu, lsam_ram.
//
// Per-label largest slice cross-section. Voxel words (operation 0) add one to
// the slice count of their label; out-of-range labels are dropped. A voxel word
// with last_in_slice set starts a sweep over all MAX_LABELS entries that raises
// each label's largest count (labels 1 to num_features-1) to its slice count and
// clears every slice count. A read word (operation 1) returns one word with the
// largest count times cell_area (UQ33.16), or zero with in_range low for labels
// at or above num_features. An in-range voxel word passes through a count
// update state; an out-of-range one goes straight back to idle unless it ends
// the slice; a read waits for the output register; an end-of-slice word adds
// the sweep through the one read and one write port of each count RAM. After
// reset a clearing pass zeroes both RAMs and o_stall stays high during it. Config
// writes (index 0 cell_area, index 1 num_features) are taken in any cycle and
// belong while the block is idle. Slice counts saturate at 131071.
module label_slice_area_max
    import lsam_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_in_word             i_word,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_out_word            o_word,
    input  logic                 i_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [AREA_W-1:0]    i_cfg_data
);

    t_mem_ctl           mem_ctl;
    t_alu_req           alu_req;
    logic [RES_W-1:0]   alu_y;
    logic [COUNT_W-1:0] slice_rd;
    logic [COUNT_W-1:0] large_rd;

    // control: handshakes, config, clear pass, sweep counter, output register
    lsam_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_word     (i_word),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_word     (o_word),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mem      (mem_ctl),
        .i_slice_rd (slice_rd),
        .i_large_rd (large_rd),
        .o_alu      (alu_req),
        .i_alu_y    (alu_y)
    );

    // one unit for count increment, sweep max and area scaling
    lsam_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    // per-label voxel count of the current slice
    lsam_ram #(
        .DEPTH (MAX_LABELS),
        .WIDTH (COUNT_W)
    ) u_slice_ram (
        .i_clk   (i_clk),
        .i_we    (mem_ctl.s_we),
        .i_waddr (mem_ctl.waddr),
        .i_wdata (mem_ctl.s_wdata),
        .i_raddr (mem_ctl.raddr),
        .o_rdata (slice_rd)
    );

    // per-label largest slice count so far
    lsam_ram #(
        .DEPTH (MAX_LABELS),
        .WIDTH (COUNT_W)
    ) u_large_ram (
        .i_clk   (i_clk),
        .i_we    (mem_ctl.l_we),
        .i_waddr (mem_ctl.waddr),
        .i_wdata (mem_ctl.l_wdata),
        .i_raddr (mem_ctl.raddr),
        .o_rdata (large_rd)
    );

endmodule

// File: sv/lsam_ram.sv
// lsam_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
module lsam_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lsam_alu.sv
// lsam_alu: shared arithmetic unit: saturating increment, max, and count x area multiply.
// Depends on lsam_pkg.
module lsam_alu
    import lsam_pkg::*;
(
    input  t_alu_req         i_req,
    output logic [RES_W-1:0] o_y
);

    always_comb begin
        o_y = '0;
        case (i_req.op)
            ALU_INC: begin
                o_y = (i_req.a == COUNT_MAX) ? RES_W'(i_req.a)
                                             : RES_W'(i_req.a) + RES_W'(1);
            end
            ALU_MAX: begin
                o_y = (i_req.a > i_req.b[COUNT_W-1:0]) ? RES_W'(i_req.a)
                                                       : RES_W'(i_req.b[COUNT_W-1:0]);
            end
            ALU_MUL: begin
                o_y = RES_W'(i_req.a) * RES_W'(i_req.b);
            end
            default: begin
                o_y = '0;
            end
        endcase
    end

endmodule

// File: sv/lsam_seq.sv
// lsam_seq: sequencer: handshakes, config registers, clear pass, slice sweep, read path.
// Depends on lsam_pkg; drives the shared ALU and both count RAMs.
module lsam_seq
    import lsam_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_in_word             i_word,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_out_word            o_word,
    input  logic                 i_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [AREA_W-1:0]    i_cfg_data,
    output t_mem_ctl             o_mem,
    input  logic [COUNT_W-1:0]   i_slice_rd,
    input  logic [COUNT_W-1:0]   i_large_rd,
    output t_alu_req             o_alu,
    input  logic [RES_W-1:0]     i_alu_y
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VOX_UPD,
        ST_SWEEP,
        ST_RD_MUL
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [LABEL_W-1:0] r_id;
    logic               r_last;
    logic               r_ok;
    logic [AREA_W-1:0]  r_cell_area;
    logic [NF_W-1:0]    r_num_features;
    logic               r_o_valid;
    t_out_word          r_o_word;

    logic               accept;
    logic               out_free;
    logic [LABEL_W-1:0] sweep_wa;
    logic               sweep_upd;

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign out_free  = !r_o_valid || !i_stall;
    assign sweep_wa  = LABEL_W'(r_cnt - CNT_W'(1));
    assign sweep_upd = (sweep_wa != '0) && in_limit(sweep_wa, r_num_features);

    always_comb begin
        o_mem         = '0;
        o_mem.raddr   = r_id;
        o_mem.waddr   = r_id;
        o_alu.op      = ALU_INC;
        o_alu.a       = i_slice_rd;
        o_alu.b       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_mem.waddr = r_cnt[LABEL_W-1:0];
                o_mem.s_we  = 1'b1;
                o_mem.l_we  = 1'b1;
            end
            ST_IDLE: begin
                o_mem.raddr = i_word.feature_id;
            end
            ST_VOX_UPD: begin
                o_mem.s_we    = 1'b1;
                o_mem.s_wdata = i_alu_y[COUNT_W-1:0];
            end
            ST_SWEEP: begin
                // read entry r_cnt, write back entry r_cnt-1 read last cycle
                o_mem.raddr = r_cnt[LABEL_W-1:0];
                o_mem.waddr = sweep_wa;
                o_alu.op    = ALU_MAX;
                o_alu.b     = AREA_W'(i_large_rd);
                if (r_cnt != '0) begin
                    o_mem.s_we    = 1'b1;
                    o_mem.l_we    = 1'b1;
                    o_mem.l_wdata = sweep_upd ? i_alu_y[COUNT_W-1:0] : i_large_rd;
                end
            end
            ST_RD_MUL: begin
                o_alu.op = ALU_MUL;
                o_alu.a  = i_large_rd;
                o_alu.b  = r_cell_area;
            end
            default: begin
                o_mem.raddr = r_id;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_cnt          <= '0;
            r_o_valid      <= 1'b0;
            r_cell_area    <= CELL_AREA_RST;
            r_num_features <= NUM_FEATURES_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELL_AREA:    r_cell_area    <= i_cfg_data;
                    CFG_NUM_FEATURES: r_num_features <= i_cfg_data[NF_W-1:0];
                    default:          r_cell_area    <= r_cell_area;
                endcase
            end

            // in ST_RD_MUL the read path below owns the output register
            if (r_o_valid && !i_stall && (r_state != ST_RD_MUL)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MAX_LABELS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_id   <= i_word.feature_id;
                        r_last <= i_word.last_in_slice;
                        r_ok   <= in_limit(i_word.feature_id, r_num_features);
                        r_cnt  <= '0;
                        if (i_word.operation == OP_READ) begin
                            r_state <= ST_RD_MUL;
                        end else if (in_limit(i_word.feature_id, r_num_features)) begin
                            r_state <= ST_VOX_UPD;
                        end else if (i_word.last_in_slice) begin
                            r_state <= ST_SWEEP;
                        end
                    end
                end
                ST_VOX_UPD: begin
                    r_state <= r_last ? ST_SWEEP : ST_IDLE;
                end
                ST_SWEEP: begin
                    if (r_cnt == CNT_W'(MAX_LABELS)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_RD_MUL: begin
                    if (out_free) begin
                        r_o_valid               <= 1'b1;
                        r_o_word.feature_id_res <= r_id;
                        r_o_word.largest_area   <= r_ok ? i_alu_y : '0;
                        r_o_word.in_range       <= r_ok;
                        r_state                 <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

endmodule

// File: sv/lsam_chk.sv
// lsam_chk: port-level checks of label_slice_area_max, bound to the top level.
// Depends on lsam_pkg.
module lsam_chk
    import lsam_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input t_in_word             i_word,
    input logic                 o_stall,
    input logic                 o_valid,
    input t_out_word            o_word,
    input logic                 i_stall
);

    // no result word right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("stalled result word changed");

    // out-of-range label reports zero area
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.in_range |-> o_word.largest_area == '0)
        else $error("out-of-range result with nonzero area");

    // an accepted read keeps the input stalled while the product is formed
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_word.operation == OP_READ |=> o_stall)
        else $error("input taken during read");

    // a new result word only appears while the input side is held off
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result word from idle state");

endmodule

bind label_slice_area_max lsam_chk u_lsam_chk (.*);

// File: dv/tb_label_slice_area_max.sv
`timescale 1ns / 1ps
// tb_label_slice_area_max: self-checking testbench of the label slice area max block.
// Depends on lsam_pkg and label_slice_area_max; holds its own model of both count stores.
module tb_label_slice_area_max;
    import lsam_pkg::*;

    // quiet cycles before the run is declared hung
    localparam int QUIET_LIMIT  = 20000;
    // cycles to let a sweep started by the last voxel word finish
    localparam int SWEEP_SETTLE = MAX_LABELS + 32;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    t_in_word             i_word;
    logic                 o_stall;
    logic                 o_valid;
    t_out_word            o_word;
    logic                 i_stall;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [AREA_W-1:0]    i_cfg_data;

    // model state: per-label counts of the open slice and largest slice count so far
    logic [COUNT_W-1:0] slice_tally [MAX_LABELS];
    logic [COUNT_W-1:0] peak_tally  [MAX_LABELS];
    logic [AREA_W-1:0]  cell_area_q;
    logic [NF_W-1:0]    num_features_q;

    t_out_word area_reports_due [$];
    t_out_word report_due;

    int n_errors      = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    label_slice_area_max dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_word     (i_word),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_word     (o_word),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // labels below min(num_features, MAX_LABELS) are live; label zero included
    function automatic logic [NF_W-1:0] active_labels();
        return (num_features_q > NF_W'(MAX_LABELS)) ? NF_W'(MAX_LABELS) : num_features_q;
    endfunction

    // Update the model with one accepted word; a read queues the word it must produce.
    function automatic void apply_label_word(input t_in_word w);
        logic      live;
        t_out_word rep;
        live = NF_W'(w.feature_id) < active_labels();
        if (w.operation == OP_VOXEL) begin
            // out-of-range labels are dropped, but their end mark still sweeps
            if (live && slice_tally[w.feature_id] != COUNT_MAX)
                slice_tally[w.feature_id] = slice_tally[w.feature_id] + 1'b1;
            if (w.last_in_slice) begin
                // label zero is never promoted; every slice count is cleared
                for (int g = 1; g < int'(active_labels()); g++)
                    if (slice_tally[g] > peak_tally[g])
                        peak_tally[g] = slice_tally[g];
                foreach (slice_tally[k])
                    slice_tally[k] = '0;
            end
        end else begin
            // end mark on a read is ignored
            rep.feature_id_res = w.feature_id;
            rep.in_range       = live;
            rep.largest_area   = live ? RES_W'(peak_tally[w.feature_id]) * RES_W'(cell_area_q)
                                      : '0;
            area_reports_due = {area_reports_due, rep};
        end
    endfunction

    // Mostly labels from a small pool so that counts build up over slices,
    // some anywhere up to the limit (limit itself included), a few anywhere.
    function automatic logic [LABEL_W-1:0] pick_label();
        int r;
        int top;
        r   = $urandom_range(99);
        top = int'(active_labels());
        if (r < 65)
            return LABEL_W'($urandom_range(0, (top > 15) ? 15 : top));
        else if (r < 90)
            return LABEL_W'($urandom_range(0, (top > 1023) ? 1023 : top));
        return LABEL_W'($urandom_range(0, 1023));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one word, hold it until taken, then maybe idle. Valid stays high
    // when no idle is drawn so back-to-back words see no bubble.
    task automatic send_item(input logic op, input logic [LABEL_W-1:0] id, input logic last);
        t_in_word w;
        w.operation     = op;
        w.feature_id    = id;
        w.last_in_slice = last;
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_label_word(w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold off until every queued read has come back.
    task automatic wait_results_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (area_reports_due.size() != 0);
    endtask

    // Voxel words give no result, so a sweep may still be running after the
    // last read returns: give it time before touching the registers.
    task automatic wait_idle();
        wait_results_done();
        repeat (SWEEP_SETTLE) @(posedge i_clk);
    endtask

    // Both registers, one after the other on back-to-back cycles; only called while idle.
    task automatic set_config(input logic [AREA_W-1:0] area, input logic [AREA_W-1:0] nf_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CELL_AREA;
        i_cfg_data <= area;
        @(posedge i_clk);
        cell_area_q = area;
        i_cfg_idx  <= CFG_NUM_FEATURES;
        i_cfg_data <= nf_data;
        @(posedge i_clk);
        num_features_q = nf_data[NF_W-1:0];
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: unit cell area, all 1024 labels live.
    task automatic test_directed_basics();
        send_item(OP_READ,  10'd0,    1'b1);   // end mark on a read: no sweep
        send_item(OP_READ,  10'd1023, 1'b0);   // top label, nothing counted yet
        send_item(OP_VOXEL, 10'd0,    1'b0);   // label zero counts but never promotes
        send_item(OP_VOXEL, 10'd1,    1'b0);
        send_item(OP_VOXEL, 10'd1,    1'b0);
        send_item(OP_VOXEL, 10'd1023, 1'b0);
        send_item(OP_VOXEL, 10'd7,    1'b1);   // end of slice, counted first
        send_item(OP_READ,  10'd0,    1'b0);
        send_item(OP_READ,  10'd1,    1'b0);
        send_item(OP_READ,  10'd1023, 1'b0);
        send_item(OP_VOXEL, 10'd1,    1'b1);   // smaller slice keeps the old peak
        send_item(OP_READ,  10'd1,    1'b0);
    endtask

    // Register extremes, each set while the block is idle.
    task automatic test_register_extremes();
        wait_idle();
        set_config(32'h0000_0000, 32'd1024);   // zero area
        send_item(OP_READ,  10'd1,    1'b0);
        wait_idle();
        set_config(32'hFFFF_FFFF, 32'd2);      // only labels 0 and 1 live
        send_item(OP_VOXEL, 10'd1,    1'b0);
        send_item(OP_VOXEL, 10'd1,    1'b0);
        send_item(OP_VOXEL, 10'd1,    1'b0);
        send_item(OP_VOXEL, 10'd2,    1'b0);   // dropped
        send_item(OP_VOXEL, 10'd1023, 1'b1);   // dropped, sweep still runs
        send_item(OP_READ,  10'd1,    1'b0);
        send_item(OP_READ,  10'd2,    1'b0);   // out of range
        send_item(OP_READ,  10'd0,    1'b0);
        wait_idle();
        set_config(32'hFFFF_FFFF, 32'd0);      // nothing live
        send_item(OP_READ,  10'd0,    1'b0);
        send_item(OP_VOXEL, 10'd0,    1'b1);
        wait_idle();
        set_config(32'h0001_0000, 32'd1);      // label zero alone
        send_item(OP_READ,  10'd0,    1'b0);
        send_item(OP_READ,  10'd1,    1'b0);
        wait_idle();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // 2047 in the low bits, capped at 1024
        send_item(OP_READ,  10'd1023, 1'b0);
    endtask

    // Well-formed slices with reads mixed in; now and then a slice runs on
    // without its end mark, and the sender pauses for the results to drain.
    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct,
                                       input logic [AREA_W-1:0] area,
                                       input logic [AREA_W-1:0] nf_data);
        int sent;
        int slice_len;
        int slice_no;
        wait_idle();
        set_config(area, nf_data);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent     = 0;
        slice_no = 0;
        while (sent < n_items) begin
            slice_len = ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            for (int v = 0; v < slice_len; v++) begin
                if ($urandom_range(3) == 0) begin
                    send_item(OP_READ, pick_label(), 1'($urandom_range(1)));
                    sent++;
                end
                send_item(OP_VOXEL, pick_label(),
                          (v == slice_len - 1) && ($urandom_range(19) != 0));
                sent++;
            end
            slice_no++;
            if (slice_no == 3 || $urandom_range(24) == 0)
                wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (slice_tally[k]) begin
            slice_tally[k] = '0;
            peak_tally[k]  = '0;
        end
        cell_area_q    = CELL_AREA_RST;
        num_features_q = NUM_FEATURES_RST;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_word     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_CELL_AREA;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 57;
        test_directed_basics();
        test_register_extremes();
        test_random_traffic(700, 18, 57, 32'($urandom), 32'd16);
        test_random_traffic(700, 57, 18, 32'($urandom), 32'($urandom_range(2, 600)));
        test_random_traffic(600, 0, 0, 32'h0001_8000, 32'd1024);
        wait_idle();

        if (n_errors == 0)
            $display("label_slice_area_max test passed");
        else
            $display("label_slice_area_max test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall, in-order compare against the model
    // ------------------------------------------------------------------
    initial i_stall = 1'b0;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (area_reports_due.size() == 0) begin
                $error("unexpected result word: feature_id_res %0d", o_word.feature_id_res);
                n_errors++;
            end else begin
                report_due = area_reports_due.pop_front();
                if (o_word.feature_id_res !== report_due.feature_id_res) begin
                    $error("feature_id_res: expected %0d, got %0d",
                           report_due.feature_id_res, o_word.feature_id_res);
                    n_errors++;
                end
                if (o_word.largest_area !== report_due.largest_area) begin
                    $error("largest_area: expected 0x%0h, got 0x%0h",
                           report_due.largest_area, o_word.largest_area);
                    n_errors++;
                end
                if (o_word.in_range !== report_due.in_range) begin
                    $error("in_range: expected %0b, got %0b",
                           report_due.in_range, o_word.in_range);
                    n_errors++;
                end
            end
        end
    end

    // Hang detector: any word moving on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("label_slice_area_max test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: sim.f
sv/lsam_pkg.sv
sv/lsam_ram.sv
sv/lsam_alu.sv
sv/lsam_seq.sv
sv/label_slice_area_max.sv
sv/lsam_chk.sv
dv/tb_label_slice_area_max.sv
